// ----- rtl/dnsa_pkg.sv -----
`timescale 1ns / 1ps

package dnsa_pkg;

    // Message and name limits
    localparam int MAX_MESSAGE_BYTES = 512;
    localparam int MAX_NAME_STEPS    = 64;

    localparam int POS_W    = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int LABELS_W = $clog2(MAX_NAME_STEPS + 1);

    // Header layout
    localparam int HDR_SHIFT_BYTES = 8;
    localparam int HDR_BYTES       = 12;

    // Question trailer and record fixed part
    localparam int QTRAIL_BYTES    = 4;
    localparam int REC_TTL_FIRST   = 4;
    localparam int REC_TTL_END     = 8;
    localparam int REC_FIXED_BYTES = 10;

    localparam logic [15:0] FLAG_QR     = 16'h8000;
    localparam logic [15:0] FLAG_RCODE  = 16'h000F;
    localparam logic [15:0] RR_TYPE_A   = 16'd1;
    localparam logic [15:0] RR_CLASS_IN = 16'd1;
    localparam logic [15:0] RR_LEN_A    = 16'd4;
    localparam logic [1:0]  LBL_PTR     = 2'b11;
    localparam logic [1:0]  LBL_PLAIN   = 2'b00;

    // Parse phases
    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_QNAME  = 4'd1;
    localparam logic [3:0] PH_QPTR   = 4'd2;
    localparam logic [3:0] PH_QTRAIL = 4'd3;
    localparam logic [3:0] PH_ANAME  = 4'd4;
    localparam logic [3:0] PH_APTR   = 4'd5;
    localparam logic [3:0] PH_AFIXED = 4'd6;
    localparam logic [3:0] PH_RDATA  = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;

    // Status codes
    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BADID     = 3'd2;
    localparam logic [2:0] ST_NOTRESP   = 3'd3;
    localparam logic [2:0] ST_BADNAME   = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;
    localparam logic [2:0] ST_NOA       = 3'd6;
    localparam logic [2:0] ST_UNDECIDED = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } msg_t;

    typedef struct packed {
        logic        found;
        logic [31:0] address;
        logic [2:0]  status;
    } res_t;

endpackage

// ----- rtl/dnsa_in_stage.sv -----
`timescale 1ns / 1ps

module dnsa_in_stage
    import dnsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic msg_valid,
    output logic msg_stall,
    input  msg_t msg,
    input  logic advance,
    output logic held_valid,
    output msg_t held
);

    logic held_valid_reg;
    logic held_valid_next;
    msg_t held_reg;
    logic load;

    // Take a new word whenever the register is empty or its word moves on
    assign load      = !held_valid_reg || advance;
    assign msg_stall = !load;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (load)
        begin
            held_valid_next = msg_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && msg_valid)
        begin
            held_reg <= msg;
        end
    end

    assign held_valid = held_valid_reg;
    assign held       = held_reg;

endmodule

// ----- rtl/dnsa_parse_core.sv -----
`timescale 1ns / 1ps

module dnsa_parse_core
    import dnsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        id_we,
    input  logic [15:0] id_wdata,
    input  logic        fire,
    input  msg_t        word,
    output logic        done,
    output res_t        result
);

    logic [15:0]         id_reg;
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [63:0]         hs_reg,      hs_next;
    logic [3:0]          phase_reg,   phase_next;
    logic [15:0]         q_reg,       q_next;
    logic [15:0]         a_reg,       a_next;
    logic [5:0]          lbl_reg,     lbl_next;
    logic [LABELS_W-1:0] labels_reg,  labels_next;
    logic [3:0]          fix_reg,     fix_next;
    logic [47:0]         rf_reg,      rf_next;
    logic [15:0]         rd_reg,      rd_next;
    logic [31:0]         addr_reg,    addr_next;
    logic [2:0]          verdict_reg, verdict_next;

    always_comb
    begin
        logic [7:0]  b;
        logic        answer;
        logic        is_a;
        logic [3:0]  fix_inc;
        logic [15:0] q_dec;
        logic [15:0] a_dec;
        logic [15:0] rd_dec;
        logic [47:0] rf_new;
        logic [15:0] hdr_id;
        logic [15:0] hdr_flags;
        logic [2:0]  st;

        b       = word.data_byte;
        answer  = (phase_reg == PH_ANAME);
        is_a    = (rf_reg[47:32] == RR_TYPE_A) && (rf_reg[31:16] == RR_CLASS_IN)
                  && (rf_reg[15:0] == RR_LEN_A);
        fix_inc = fix_reg + 4'd1;
        q_dec   = q_reg - 16'd1;
        a_dec   = a_reg - 16'd1;
        rd_dec  = rd_reg - 16'd1;
        rf_new  = ((fix_reg < 4'(REC_TTL_FIRST)) || (fix_reg >= 4'(REC_TTL_END)))
                  ? {rf_reg[39:0], b} : rf_reg;
        hdr_id    = hs_reg[63:48];
        hdr_flags = hs_reg[47:32];
        st        = ST_UNDECIDED;

        pos_next     = pos_reg;
        hs_next      = hs_reg;
        phase_next   = phase_reg;
        q_next       = q_reg;
        a_next       = a_reg;
        lbl_next     = lbl_reg;
        labels_next  = labels_reg;
        fix_next     = fix_reg;
        rf_next      = rf_reg;
        rd_next      = rd_reg;
        addr_next    = addr_reg;
        verdict_next = verdict_reg;

        result = '0;
        done   = fire && word.last_byte;

        if (fire)
        begin
            if (pos_reg < POS_W'(MAX_MESSAGE_BYTES))
            begin
                pos_next = pos_reg + POS_W'(1);
                if (verdict_reg == ST_UNDECIDED)
                begin
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            if (pos_reg < POS_W'(HDR_SHIFT_BYTES))
                            begin
                                hs_next = {hs_reg[55:0], b};
                            end
                            if (pos_reg == POS_W'(HDR_BYTES - 1))
                            begin
                                if (hdr_id != id_reg)
                                begin
                                    verdict_next = ST_BADID;
                                    phase_next   = PH_DONE;
                                end
                                else if (((hdr_flags & FLAG_QR) == 16'd0)
                                         || ((hdr_flags & FLAG_RCODE) != 16'd0))
                                begin
                                    verdict_next = ST_NOTRESP;
                                    phase_next   = PH_DONE;
                                end
                                else
                                begin
                                    q_next = hs_reg[31:16];
                                    a_next = hs_reg[15:0];
                                    if (hs_reg[31:16] != 16'd0)
                                    begin
                                        phase_next  = PH_QNAME;
                                        lbl_next    = '0;
                                        labels_next = '0;
                                    end
                                    else if (hs_reg[15:0] == 16'd0)
                                    begin
                                        verdict_next = ST_NOA;
                                        phase_next   = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next  = PH_ANAME;
                                        lbl_next    = '0;
                                        labels_next = '0;
                                    end
                                end
                            end
                        end
                        PH_QNAME, PH_ANAME:
                        begin
                            if (lbl_reg != 6'd0)
                            begin
                                lbl_next = lbl_reg - 6'd1;
                            end
                            else if (labels_reg >= LABELS_W'(MAX_NAME_STEPS))
                            begin
                                verdict_next = ST_BADNAME;
                                phase_next   = PH_DONE;
                            end
                            else if (b == 8'd0)
                            begin
                                fix_next = '0;
                                if (answer)
                                begin
                                    rf_next    = '0;
                                    phase_next = PH_AFIXED;
                                end
                                else
                                begin
                                    phase_next = PH_QTRAIL;
                                end
                            end
                            else if (b[7:6] == LBL_PTR)
                            begin
                                phase_next = answer ? PH_APTR : PH_QPTR;
                            end
                            else if (b[7:6] != LBL_PLAIN)
                            begin
                                verdict_next = ST_BADNAME;
                                phase_next   = PH_DONE;
                            end
                            else
                            begin
                                labels_next = labels_reg + LABELS_W'(1);
                                lbl_next    = b[5:0];
                            end
                        end
                        PH_QPTR:
                        begin
                            fix_next   = '0;
                            phase_next = PH_QTRAIL;
                        end
                        PH_APTR:
                        begin
                            fix_next   = '0;
                            rf_next    = '0;
                            phase_next = PH_AFIXED;
                        end
                        PH_QTRAIL:
                        begin
                            fix_next = fix_inc;
                            if (fix_inc >= 4'(QTRAIL_BYTES))
                            begin
                                q_next = q_dec;
                                if (q_dec != 16'd0)
                                begin
                                    phase_next  = PH_QNAME;
                                    lbl_next    = '0;
                                    labels_next = '0;
                                end
                                else if (a_reg == 16'd0)
                                begin
                                    verdict_next = ST_NOA;
                                    phase_next   = PH_DONE;
                                end
                                else
                                begin
                                    phase_next  = PH_ANAME;
                                    lbl_next    = '0;
                                    labels_next = '0;
                                end
                            end
                        end
                        PH_AFIXED:
                        begin
                            rf_next  = rf_new;
                            fix_next = fix_inc;
                            if (fix_inc >= 4'(REC_FIXED_BYTES))
                            begin
                                rd_next   = rf_new[15:0];
                                addr_next = '0;
                                if (rf_new[15:0] == 16'd0)
                                begin
                                    a_next = a_dec;
                                    if (a_dec == 16'd0)
                                    begin
                                        verdict_next = ST_NOA;
                                        phase_next   = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next  = PH_ANAME;
                                        lbl_next    = '0;
                                        labels_next = '0;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_RDATA;
                                end
                            end
                        end
                        PH_RDATA:
                        begin
                            if (is_a)
                            begin
                                addr_next = {addr_reg[23:0], b};
                            end
                            rd_next = rd_dec;
                            if (rd_dec == 16'd0)
                            begin
                                if (is_a)
                                begin
                                    verdict_next = ST_FOUND;
                                    phase_next   = PH_DONE;
                                end
                                else
                                begin
                                    a_next = a_dec;
                                    if (a_dec == 16'd0)
                                    begin
                                        verdict_next = ST_NOA;
                                        phase_next   = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next  = PH_ANAME;
                                        lbl_next    = '0;
                                        labels_next = '0;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            if (word.last_byte)
            begin
                st = verdict_next;
                if (st == ST_UNDECIDED)
                begin
                    st = (phase_next == PH_HEADER) ? ST_SHORT : ST_TRUNC;
                end
                result.found   = (st == ST_FOUND);
                result.address = (st == ST_FOUND) ? addr_next : 32'd0;
                result.status  = st;

                // Clear for the next message
                pos_next     = '0;
                hs_next      = '0;
                phase_next   = PH_HEADER;
                q_next       = '0;
                a_next       = '0;
                lbl_next     = '0;
                labels_next  = '0;
                fix_next     = '0;
                rf_next      = '0;
                rd_next      = '0;
                addr_next    = '0;
                verdict_next = ST_UNDECIDED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg      <= '0;
            pos_reg     <= '0;
            hs_reg      <= '0;
            phase_reg   <= PH_HEADER;
            q_reg       <= '0;
            a_reg       <= '0;
            lbl_reg     <= '0;
            labels_reg  <= '0;
            fix_reg     <= '0;
            rf_reg      <= '0;
            rd_reg      <= '0;
            addr_reg    <= '0;
            verdict_reg <= ST_UNDECIDED;
        end
        else
        begin
            if (id_we)
            begin
                id_reg <= id_wdata;
            end
            pos_reg     <= pos_next;
            hs_reg      <= hs_next;
            phase_reg   <= phase_next;
            q_reg       <= q_next;
            a_reg       <= a_next;
            lbl_reg     <= lbl_next;
            labels_reg  <= labels_next;
            fix_reg     <= fix_next;
            rf_reg      <= rf_next;
            rd_reg      <= rd_next;
            addr_reg    <= addr_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

// ----- rtl/dnsa_out_stage.sv -----
`timescale 1ns / 1ps

module dnsa_out_stage
    import dnsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t load_word,
    output logic blocked,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;

    assign blocked = res_valid_reg && res_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_word;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/dns_a_record_response_parser_unit.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Word
// msg      in         msg_valid / msg_stall  msg_t: data_byte, last_byte
// res      out        res_valid / res_stall  res_t: found, address, status
// id       in         id_we (no stall)       id_wdata: expected transaction id
//
// One byte is taken every cycle unless the input stalls; a result is offered once
// the last byte leaves the input register (the parser and result load together).
// Parser state updates in one pass over a held byte per cycle while it advances.
// rst_n clears the parser, the expected id and both valid flags asynchronously.
// Stalls: a held result blocks only a last-byte word; that word then waits in the
// input register and stalls the input until the result is taken.

module dns_a_record_response_parser_unit
    import dnsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  msg_t        msg,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res,
    input  logic        id_we,
    input  logic [15:0] id_wdata
);

    logic held_valid;
    msg_t held;
    logic advance;
    logic blocked;
    logic done;
    res_t result;

    // Advance the held word unless it closes a message while the result slot is full
    assign advance = held_valid && (!held.last_byte || !blocked);

    dnsa_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_valid  (msg_valid),
        .msg_stall  (msg_stall),
        .msg        (msg),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    dnsa_parse_core u_parse_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .id_we    (id_we),
        .id_wdata (id_wdata),
        .fire     (advance),
        .word     (held),
        .done     (done),
        .result   (result)
    );

    dnsa_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (done),
        .load_word (result),
        .blocked   (blocked),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`ifndef SYNTHESIS
    // Input may only stall because a finished result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        msg_stall |-> (res_valid && res_stall))
        else $error("input stalled without a blocked result");

    // Found flag and status code agree
    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.found == (res.status == ST_FOUND)))
        else $error("found flag disagrees with status");

    // Address is zero when nothing was found
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.found) |-> (res.address == 32'd0))
        else $error("address nonzero without a found record");

    // A result appears only after a last-byte word went through the parser
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(advance && held.last_byte))
        else $error("result without a closing byte");
`endif

endmodule
